[src/sbfd_pkg.sv]
// ----------------------------------------------------------------------------
// sbfd_pkg
// Shared constants and types of the SBUS frame decoder: frame layout, start
// and end marks, register indexes, and the structs for buffer writes from
// the byte intake and for decoded channel results.
// ----------------------------------------------------------------------------
package sbfd_pkg;

    // Number of proportional channels carried by one frame.
    localparam int NUM_CHANNELS_DEF = 16;

    // Frame layout: 24 buffered bytes (start, 22 data, flags) plus end mark.
    localparam int BUF_DEPTH  = 24;
    localparam int BUF_ADDR_W = 5;
    localparam logic [BUF_ADDR_W-1:0] LAST_BUF_POS = 5'd23;
    localparam logic [BUF_ADDR_W-1:0] END_POS      = 5'd24;
    localparam logic [BUF_ADDR_W-1:0] FLAG_BYTE    = 5'd23;
    localparam logic [BUF_ADDR_W-1:0] FIRST_DATA   = 5'd1;

    // Frame marks.
    localparam logic [7:0] START_MAIN = 8'h0F;
    localparam logic [7:0] START_ALT  = 8'hF8;
    localparam logic [7:0] END_MARK   = 8'h00;

    // Channel unpacking: 11-bit values, bit accumulator wide enough for
    // ten leftover bits plus one fresh byte.
    localparam int CH_BITS = 11;
    localparam int ACC_W   = 18;
    localparam int CNT_W   = 5;

    // Field widths.
    localparam int GAP_W   = 16;
    localparam int CH_IDX_W = 4;

    // Configuration registers.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_GAP = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALT_START = 2'd1;
    localparam logic [GAP_W-1:0] MIN_GAP_RESET = 16'd3000;
    localparam logic ALT_START_RESET = 1'b1;

    // Write into the frame buffer.
    typedef struct packed {
        logic                  en;
        logic [BUF_ADDR_W-1:0] addr;
        logic [7:0]            data;
    } buf_wr_t;

    // One decoded channel result.
    typedef struct packed {
        logic                  last;
        logic                  failsafe_active;
        logic                  frame_lost;
        logic                  digital_two;
        logic                  digital_one;
        logic [CH_BITS-1:0]    channel_value;
        logic [CH_IDX_W-1:0]   channel_index;
    } chan_beat_t;

endpackage

[src/sbfd_decode.sv]
// ----------------------------------------------------------------------------
// sbfd_decode
// Frame buffer and channel decoder. Holds the buffered frame bytes in a
// synchronous memory; after a good frame it reads the flag byte, then walks
// the data bytes through a bit accumulator and emits one channel per beat.
// ----------------------------------------------------------------------------
module sbfd_decode #(
    parameter int NUM_CHANNELS = sbfd_pkg::NUM_CHANNELS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  sbfd_pkg::buf_wr_t   wr,
    input  logic                start,
    output logic                busy,
    output logic                out_valid,
    input  logic                out_ready,
    output sbfd_pkg::chan_beat_t out_beat
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FLAG  = 3'd1;
    localparam logic [2:0] S_FLAGD = 3'd2;
    localparam logic [2:0] S_FETCH = 3'd3;
    localparam logic [2:0] S_LOAD  = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    localparam logic [sbfd_pkg::CH_IDX_W-1:0] LAST_CH =
        sbfd_pkg::CH_IDX_W'(NUM_CHANNELS - 1);
    localparam logic [sbfd_pkg::CNT_W-1:0] CH_BITS_C =
        sbfd_pkg::CNT_W'(sbfd_pkg::CH_BITS);
    localparam logic [sbfd_pkg::CNT_W-1:0] BYTE_BITS = 5'd8;

    logic [7:0] mem [sbfd_pkg::BUF_DEPTH];
    logic [7:0] rd_data_reg;
    logic [sbfd_pkg::BUF_ADDR_W-1:0] rd_addr;

    logic [2:0] state_reg, state_next;
    logic [sbfd_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic [sbfd_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [sbfd_pkg::CH_IDX_W-1:0] ch_reg, ch_next;
    logic [sbfd_pkg::BUF_ADDR_W-1:0] addr_reg, addr_next;
    logic [7:0] flags_reg, flags_next;
    logic out_valid_reg, out_valid_next;
    sbfd_pkg::chan_beat_t out_beat_reg, out_beat_next;
    logic emit_go;

    // Frame buffer: one write port from the intake, one registered read port.
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Read address: the flag byte first, then data bytes in order.
    assign rd_addr = (state_reg == S_FLAG) ? sbfd_pkg::FLAG_BYTE : addr_reg;

    // An emit proceeds once the output register is free or being drained.
    assign emit_go = (state_reg == S_EMIT) && (!out_valid_reg || out_ready);

    // Sequencer and bit accumulator.
    always_comb begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        ch_next        = ch_reg;
        addr_next      = addr_reg;
        flags_next     = flags_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_beat_next  = out_beat_reg;
        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    state_next = S_FLAG;
                    acc_next   = '0;
                    cnt_next   = '0;
                    ch_next    = '0;
                    addr_next  = sbfd_pkg::FIRST_DATA;
                end
            end
            S_FLAG: begin
                state_next = S_FLAGD;
            end
            S_FLAGD: begin
                flags_next = rd_data_reg;
                state_next = S_FETCH;
            end
            S_FETCH: begin
                if (cnt_reg >= CH_BITS_C) begin
                    state_next = S_EMIT;
                end else begin
                    addr_next  = addr_reg + 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_LOAD: begin
                acc_next   = acc_reg | (sbfd_pkg::ACC_W'(rd_data_reg) << cnt_reg);
                cnt_next   = cnt_reg + BYTE_BITS;
                state_next = S_FETCH;
            end
            S_EMIT: begin
                if (emit_go) begin
                    out_valid_next                = 1'b1;
                    out_beat_next.channel_index   = ch_reg;
                    out_beat_next.channel_value   = acc_reg[sbfd_pkg::CH_BITS-1:0];
                    out_beat_next.digital_one     = flags_reg[7];
                    out_beat_next.digital_two     = flags_reg[6];
                    out_beat_next.frame_lost      = flags_reg[5];
                    out_beat_next.failsafe_active = flags_reg[4];
                    out_beat_next.last            = (ch_reg == LAST_CH);
                    acc_next = acc_reg >> sbfd_pkg::CH_BITS;
                    cnt_next = cnt_reg - CH_BITS_C;
                    ch_next  = ch_reg + 1'b1;
                    state_next = (ch_reg == LAST_CH) ? S_IDLE : S_FETCH;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state is reset; payload registers are not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        acc_reg      <= acc_next;
        cnt_reg      <= cnt_next;
        ch_reg       <= ch_next;
        addr_reg     <= addr_next;
        flags_reg    <= flags_next;
        out_beat_reg <= out_beat_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_beat  = out_beat_reg;

    // The intake never writes the buffer while a frame is being decoded.
    a_no_write_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr.en || start) |-> !busy)
        else $error("frame buffer written during decode");

    // The accumulator never holds more bits than it is wide.
    a_acc_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FETCH || state_reg == S_EMIT) |->
        (cnt_reg <= sbfd_pkg::CNT_W'(sbfd_pkg::ACC_W)))
        else $error("bit accumulator overflow");

    // Data reads stay within the buffered data bytes.
    a_addr_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LOAD) |-> (addr_reg <= sbfd_pkg::FLAG_BYTE))
        else $error("data read past the flag byte");

    // The last channel returns the sequencer to idle with a marked beat.
    a_last_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit_go && ch_reg == LAST_CH) |=>
        (state_reg == S_IDLE && out_valid_reg && out_beat_reg.last))
        else $error("last channel did not close the frame");

endmodule

[src/sbus_frame_decoder.sv]
// ----------------------------------------------------------------------------
// sbus_frame_decoder
// SBUS receiver frame decoder: assembles 25-byte frames from received bytes
// and emits one beat per proportional channel on a good frame.
// ----------------------------------------------------------------------------
// A byte is taken whenever no frame is being decoded. Bytes 0 to 23
// go into a 24-entry frame buffer memory; byte 24 closes the frame. If it is
// 0x00, the decoder reads the flag byte and then the data bytes one per
// memory read, and emits the channels in order, channel 0 first, with tlast
// on the final one. A good frame keeps the input stalled until the decoder
// has emitted its last channel into the output register, which output
// back-pressure can delay; the data bytes are read one at a time through
// the single read port of the frame buffer, one channel per check. A
// byte at frame position 0 is dropped unless the gap before it is at least
// min_gap_us and it is a start byte (0x0F, or 0xF8 when accept_alt_start is
// set). The configuration channel is always ready; index 0 is min_gap_us,
// index 1 is accept_alt_start, other indexes are ignored.
// ----------------------------------------------------------------------------
module sbus_frame_decoder #(
    parameter int NUM_CHANNELS = sbfd_pkg::NUM_CHANNELS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sbfd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sbfd_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Received byte stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata: [7:0] rx_byte, [23:8] gap_us
    input  logic [23:0]                         s_tdata,
    // Channel result stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata: [3:0] channel_index, [14:4] channel_value, [15] digital_one,
    // [16] digital_two, [17] frame_lost, [18] failsafe_active, [23:19] zero
    output logic [23:0]                         m_tdata,
    output logic                                m_tlast
);

    logic [sbfd_pkg::GAP_W-1:0] min_gap_reg;
    logic alt_start_reg;
    logic [sbfd_pkg::BUF_ADDR_W-1:0] pos_reg, pos_next;

    logic [7:0] rx_byte;
    logic [sbfd_pkg::GAP_W-1:0] gap_us;
    logic in_beat;
    logic start_ok;
    logic dec_busy;
    logic dec_start;
    sbfd_pkg::buf_wr_t buf_wr;
    sbfd_pkg::chan_beat_t out_beat;

    assign rx_byte = s_tdata[7:0];
    assign gap_us  = s_tdata[23:8];

    // Configuration registers.
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_gap_reg   <= sbfd_pkg::MIN_GAP_RESET;
            alt_start_reg <= sbfd_pkg::ALT_START_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                sbfd_pkg::CFG_MIN_GAP:   min_gap_reg   <= cfg_data;
                sbfd_pkg::CFG_ALT_START: alt_start_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Input beats are taken whenever the decoder is idle.
    assign s_tready = !dec_busy;
    assign in_beat  = s_tvalid && s_tready;

    // Frame start check: long enough gap and a valid start byte.
    assign start_ok = (gap_us >= min_gap_reg) &&
                      ((rx_byte == sbfd_pkg::START_MAIN) ||
                       (alt_start_reg && rx_byte == sbfd_pkg::START_ALT));

    // Byte position tracking, buffer writes and frame close.
    always_comb begin
        pos_next    = pos_reg;
        buf_wr.en   = 1'b0;
        buf_wr.addr = pos_reg;
        buf_wr.data = rx_byte;
        dec_start   = 1'b0;
        if (in_beat) begin
            if (pos_reg == sbfd_pkg::END_POS) begin
                pos_next  = '0;
                dec_start = (rx_byte == sbfd_pkg::END_MARK);
            end else if (pos_reg != '0 || start_ok) begin
                buf_wr.en = 1'b1;
                pos_next  = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else begin
            pos_reg <= pos_next;
        end
    end

    sbfd_decode #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr        (buf_wr),
        .start     (dec_start),
        .busy      (dec_busy),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_beat  (out_beat)
    );

    // Result beat packing.
    assign m_tdata = {5'd0,
                      out_beat.failsafe_active,
                      out_beat.frame_lost,
                      out_beat.digital_two,
                      out_beat.digital_one,
                      out_beat.channel_value,
                      out_beat.channel_index};
    assign m_tlast = out_beat.last;

    // The position counter never runs past the end mark.
    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= sbfd_pkg::END_POS)
        else $error("byte position out of range");

    // Closing a frame always returns the position to zero.
    a_close_resets_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_beat && pos_reg == sbfd_pkg::END_POS) |=> (pos_reg == '0))
        else $error("frame close did not reset position");

    // A good end mark starts the decoder on the next cycle.
    a_good_frame_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        dec_start |=> dec_busy)
        else $error("decoder did not start on a good frame");

endmodule
